// ===== hdl/stt_pkg.sv =====
`timescale 1ns / 1ps

package stt_pkg;

    // Field widths fixed by the item format
    localparam int CNT_W  = 32;
    localparam int IDX_W  = 3;
    localparam int MASK_W = 8;
    localparam int OP_W   = 2;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    typedef logic [OP_W-1:0] op_t;

    // Item operations
    localparam op_t OP_TICK   = 2'd0;
    localparam op_t OP_ARM    = 2'd1;
    localparam op_t OP_DISARM = 2'd2;
    localparam op_t OP_ACK    = 2'd3;

    // Register select (paddr bit 2)
    localparam logic REG_CPS = 1'b0;
    localparam logic REG_CPT = 1'b1;

    localparam logic [CNT_W-1:0] CPS_RESET = 32'd72000000;
    localparam logic [CNT_W-1:0] CPT_RESET = 32'd140625;

    // One item being processed this cycle
    typedef struct packed {
        logic             go;
        op_t              op;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] dur;
    } step_t;

endpackage

// ===== hdl/stt_timebase.sv =====
`timescale 1ns / 1ps

module stt_timebase (
    input  logic                  clk,
    input  logic                  rst_n,
    input  stt_pkg::step_t        step,
    input  logic [stt_pkg::CNT_W-1:0] cps,
    input  logic [stt_pkg::CNT_W-1:0] cpt,
    output logic [stt_pkg::CNT_W-1:0] ticks_next,
    output logic [stt_pkg::CNT_W-1:0] seconds_next
);
    import stt_pkg::*;

    logic [CNT_W-1:0] ticks_reg;
    logic [CNT_W-1:0] rem_reg;
    logic [CNT_W-1:0] sec_reg;
    logic [CNT_W-1:0] rem_next;
    logic [CNT_W-1:0] rem_sum;
    logic             is_tick;
    logic             roll;

    // Tick count and seconds remainder update
    always_comb
    begin
        is_tick      = step.go && (step.op == OP_TICK);
        rem_sum      = rem_reg + cpt;
        roll         = (rem_sum >= cps);
        ticks_next   = ticks_reg;
        rem_next     = rem_reg;
        seconds_next = sec_reg;
        if (is_tick)
        begin
            ticks_next = ticks_reg + 32'd1;
            if (roll)
            begin
                rem_next     = rem_sum - cps;
                seconds_next = sec_reg + 32'd1;
            end
            else
            begin
                rem_next = rem_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg <= '0;
            rem_reg   <= '0;
            sec_reg   <= '0;
        end
        else
        begin
            ticks_reg <= ticks_next;
            rem_reg   <= rem_next;
            sec_reg   <= seconds_next;
        end
    end

endmodule

// ===== hdl/stt_timer_bank.sv =====
`timescale 1ns / 1ps

module stt_timer_bank #(
    parameter int NUM_TIMERS = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  stt_pkg::step_t             step,
    input  logic [stt_pkg::CNT_W-1:0]  ticks_next,
    output logic [stt_pkg::MASK_W-1:0] fired_mask,
    output logic [stt_pkg::MASK_W-1:0] elapsed_mask
);
    import stt_pkg::*;

    logic [NUM_TIMERS-1:0] armed_reg;
    logic [NUM_TIMERS-1:0] armed_next;
    logic [NUM_TIMERS-1:0] elapsed_reg;
    logic [NUM_TIMERS-1:0] elapsed_next;
    logic [NUM_TIMERS-1:0] fired;
    logic [CNT_W-1:0]      period_reg   [NUM_TIMERS];
    logic [CNT_W-1:0]      period_next  [NUM_TIMERS];
    logic [CNT_W-1:0]      deadline_reg [NUM_TIMERS];
    logic [CNT_W-1:0]      deadline_next[NUM_TIMERS];

    // Per-timer update, all timers side by side
    always_comb
    begin
        for (int k = 0; k < NUM_TIMERS; k++)
        begin
            armed_next[k]    = armed_reg[k];
            elapsed_next[k]  = elapsed_reg[k];
            period_next[k]   = period_reg[k];
            deadline_next[k] = deadline_reg[k];
            fired[k]         = 1'b0;
            if (step.go)
            begin
                if (step.op == OP_TICK)
                begin
                    // ticks_next is the count after this tick
                    if (armed_reg[k] && (ticks_next >= deadline_reg[k]))
                    begin
                        deadline_next[k] = deadline_reg[k] + period_reg[k];
                        elapsed_next[k]  = 1'b1;
                        fired[k]         = 1'b1;
                    end
                end
                else if (int'(step.idx) == k)
                begin
                    unique case (step.op)
                        OP_ARM:
                        begin
                            armed_next[k]    = 1'b1;
                            period_next[k]   = step.dur;
                            deadline_next[k] = ticks_next + step.dur;
                            elapsed_next[k]  = 1'b0;
                        end
                        OP_DISARM:
                        begin
                            armed_next[k]   = 1'b0;
                            elapsed_next[k] = 1'b0;
                        end
                        default:
                        begin
                            elapsed_next[k] = 1'b0;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg   <= '0;
            elapsed_reg <= '0;
            for (int k = 0; k < NUM_TIMERS; k++)
            begin
                period_reg[k]   <= '0;
                deadline_reg[k] <= '0;
            end
        end
        else
        begin
            armed_reg   <= armed_next;
            elapsed_reg <= elapsed_next;
            for (int k = 0; k < NUM_TIMERS; k++)
            begin
                period_reg[k]   <= period_next[k];
                deadline_reg[k] <= deadline_next[k];
            end
        end
    end

    // Only the low timers show in the masks
    generate
        for (genvar m = 0; m < MASK_W; m++)
        begin : g_mask
            if (m < NUM_TIMERS)
            begin : g_on
                assign fired_mask[m]   = fired[m];
                assign elapsed_mask[m] = elapsed_next[m];
            end
            else
            begin : g_off
                assign fired_mask[m]   = 1'b0;
                assign elapsed_mask[m] = 1'b0;
            end
        end
    endgenerate

endmodule

// ===== hdl/system_tick_with_periodic_timers.sv =====
`timescale 1ns / 1ps
// An item passes the input register and then the result register before out_valid rises.
// Throughput: one item per cycle while out_ready is high; all counters and the timer comparators update in one pass.
// Output stalls back up through the result register into the input register.
// Reset (rst_n low, asynchronous): counts, remainder and seconds clear, all timers disarmed
// and acknowledged, cycles_per_second = 72000000, cycles_per_tick = 140625.

module system_tick_with_periodic_timers #(
    parameter int NUM_TIMERS = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // Configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [stt_pkg::PADDR_W-1:0]  paddr,
    input  logic [stt_pkg::PDATA_W-1:0]  pwdata,
    output logic [stt_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    // Item input
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [stt_pkg::OP_W-1:0]     op,
    input  logic [stt_pkg::IDX_W-1:0]    timer_index,
    input  logic [stt_pkg::CNT_W-1:0]    duration,
    // Result output
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [stt_pkg::CNT_W-1:0]    tick_count,
    output logic [stt_pkg::CNT_W-1:0]    seconds,
    output logic [stt_pkg::MASK_W-1:0]   fired_mask,
    output logic [stt_pkg::MASK_W-1:0]   elapsed_mask
);
    import stt_pkg::*;

    logic [CNT_W-1:0]  cps_reg;
    logic [CNT_W-1:0]  cpt_reg;
    logic              in_vld_reg;
    op_t               op_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  dur_reg;
    logic              out_vld_reg;
    logic [CNT_W-1:0]  tick_reg;
    logic [CNT_W-1:0]  sec_reg;
    logic [MASK_W-1:0] fired_reg;
    logic [MASK_W-1:0] elapsed_reg;
    logic              advance;
    logic              cfg_wr;
    step_t             step;
    logic [CNT_W-1:0]  ticks_next;
    logic [CNT_W-1:0]  seconds_next;
    logic [MASK_W-1:0] fired_next;
    logic [MASK_W-1:0] elapsed_next;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cps_reg <= CPS_RESET;
            cpt_reg <= CPT_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_CPS)
                cps_reg <= pwdata;
            else
                cpt_reg <= pwdata;
        end
    end

    assign prdata = (paddr[2] == REG_CPT) ? cpt_reg : cps_reg;

    // Input register stage
    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_ready)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg  <= op;
            idx_reg <= timer_index;
            dur_reg <= duration;
        end
    end

    assign step.go  = advance;
    assign step.op  = op_reg;
    assign step.idx = idx_reg;
    assign step.dur = dur_reg;

    stt_timebase u_timebase (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .cps          (cps_reg),
        .cpt          (cpt_reg),
        .ticks_next   (ticks_next),
        .seconds_next (seconds_next)
    );

    stt_timer_bank #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_timer_bank (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .ticks_next   (ticks_next),
        .fired_mask   (fired_next),
        .elapsed_mask (elapsed_next)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
            tick_reg    <= '0;
            sec_reg     <= '0;
            fired_reg   <= '0;
            elapsed_reg <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_vld_reg <= 1'b1;
                tick_reg    <= ticks_next;
                sec_reg     <= seconds_next;
                fired_reg   <= fired_next;
                elapsed_reg <= elapsed_next;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_vld_reg;
    assign tick_count   = tick_reg;
    assign seconds      = sec_reg;
    assign fired_mask   = fired_reg;
    assign elapsed_mask = elapsed_reg;

    // Only a tick transfer can fire timers
    a_fire_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (op_reg != OP_TICK)) |=> (fired_mask == '0))
        else $error("timer fired on a non-tick transfer");

    // A tick advances the count by exactly one
    a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (op_reg == OP_TICK)) |=> (tick_count == 32'($past(tick_count) + 32'd1)))
        else $error("tick count did not advance by one");

    // A timer that fired is also marked elapsed
    a_fired_elapsed: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> ((fired_mask & ~elapsed_mask) == '0))
        else $error("fired timer not marked elapsed");

endmodule
